### hdl/rgbled_pkg.sv
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types, constants and helpers of the one-wire RGB LED serializer.
// ----------------------------------------------------------------------------
package rgbled_pkg;

    localparam int NUM_LEDS_DEF = 64;

    localparam int LED_NUM_W  = 10;
    localparam int COLOUR_W   = 8;
    localparam int SHORT_W    = 16;
    localparam int LONG_W     = 16;
    localparam int LATCH_W    = 20;
    localparam int ORDER_W    = 3;
    localparam int ROW_W      = 3 * COLOUR_W;
    localparam int BIT_W      = 5;
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(ROW_W - 1);

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;

    localparam logic [1:0] REG_SHORT = 2'd0;
    localparam logic [1:0] REG_LONG  = 2'd1;
    localparam logic [1:0] REG_LATCH = 2'd2;
    localparam logic [1:0] REG_ORDER = 2'd3;

    localparam logic [SHORT_W-1:0] SHORT_RST = 16'd30;
    localparam logic [LONG_W-1:0]  LONG_RST  = 16'd90;
    localparam logic [LATCH_W-1:0] LATCH_RST = 20'd8000;
    localparam logic [ORDER_W-1:0] ORDER_RST = 3'd2;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_LATCH = 2'd3;

    localparam logic [ORDER_W-1:0] ORD_RGB = 3'd0;
    localparam logic [ORDER_W-1:0] ORD_RBG = 3'd1;
    localparam logic [ORDER_W-1:0] ORD_GRB = 3'd2;
    localparam logic [ORDER_W-1:0] ORD_GBR = 3'd3;
    localparam logic [ORDER_W-1:0] ORD_BRG = 3'd4;
    localparam logic [ORDER_W-1:0] ORD_BGR = 3'd5;

    typedef struct packed {
        logic [SHORT_W-1:0] short_ticks;
        logic [LONG_W-1:0]  long_ticks;
        logic [LATCH_W-1:0] latch_ticks;
        logic [ORDER_W-1:0] channel_order;
    } cfg_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
    } result_t;

    // first byte on the line sits in the top bits of a row
    function automatic logic [ROW_W-1:0] build_row(
        input logic [ORDER_W-1:0]  order,
        input logic [COLOUR_W-1:0] r,
        input logic [COLOUR_W-1:0] g,
        input logic [COLOUR_W-1:0] b
    );
        logic [ROW_W-1:0] row;
        case (order)
            ORD_RGB: row = {r, g, b};
            ORD_RBG: row = {r, b, g};
            ORD_GRB: row = {g, r, b};
            ORD_GBR: row = {g, b, r};
            ORD_BRG: row = {b, r, g};
            ORD_BGR: row = {b, g, r};
            default: row = {g, r, b};
        endcase
        return row;
    endfunction

endpackage

### hdl/rgbled_ram.sv
// ----------------------------------------------------------------------------
// rgbled_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbled_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/rgbled_seq.sv
// ----------------------------------------------------------------------------
// rgbled_seq
// Colour store control, clearing pass and one-wire bit timing.
// ----------------------------------------------------------------------------
module rgbled_seq
    import rgbled_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 item_fire,
    input  logic                 action,
    input  logic [LED_NUM_W-1:0] led_number,
    input  logic [COLOUR_W-1:0]  red,
    input  logic [COLOUR_W-1:0]  green,
    input  logic [COLOUR_W-1:0]  blue,
    output result_t              res,
    output logic                 clear_busy
);

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int CW = $clog2(NUM_LEDS + 1);
    localparam logic [AW-1:0]        LAST_ROW = AW'(NUM_LEDS - 1);
    localparam logic [CW-1:0]        CLR_END  = CW'(NUM_LEDS);
    localparam logic [LED_NUM_W-1:0] LED_MAX  = LED_NUM_W'(NUM_LEDS);

    logic                clearing_reg;
    logic [CW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [1:0]          phase_reg, phase_next;
    logic [LATCH_W-1:0]  tick_reg, tick_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [AW-1:0]       row_reg, row_next;
    logic [ROW_W-1:0]    cur_reg, cur_next;

    logic                set_ok;
    logic                led_ok;
    logic [LED_NUM_W-1:0] led_m1;
    logic [ROW_W-1:0]    new_row;
    logic [LATCH_W-1:0]  tick_inc;
    logic [SHORT_W-1:0]  part_len;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ROW_W-1:0]    ram_rdata;

    assign led_m1  = led_number - LED_NUM_W'(1);
    assign led_ok  = (led_number != '0) && (led_number <= LED_MAX);
    assign new_row = build_row(cfg.channel_order, red, green, blue);
    assign tick_inc = tick_reg + LATCH_W'(1);
    assign part_len = ((phase_reg == PH_HIGH) == cur_reg[ROW_W-1]) ? cfg.long_ticks
                                                                   : cfg.short_ticks;

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        row_next   = row_reg;
        cur_next   = cur_reg;
        set_ok     = 1'b0;
        if (item_fire) begin
            if (action == ACT_TICK) begin
                case (phase_reg)
                    PH_LATCH: begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.latch_ticks) begin
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                        end
                    end
                    PH_HIGH, PH_LOW: begin
                        tick_next = tick_inc;
                        if (tick_inc >= LATCH_W'(part_len)) begin
                            tick_next = '0;
                            if (phase_reg == PH_HIGH) begin
                                phase_next = PH_LOW;
                            end else if (bit_reg != LAST_BIT) begin
                                bit_next   = bit_reg + BIT_W'(1);
                                cur_next   = {cur_reg[ROW_W-2:0], 1'b0};
                                phase_next = PH_HIGH;
                            end else begin
                                bit_next = '0;
                                if (row_reg == LAST_ROW) begin
                                    row_next   = '0;
                                    phase_next = PH_LATCH;
                                end else begin
                                    row_next   = row_reg + AW'(1);
                                    cur_next   = ram_rdata;
                                    phase_next = PH_HIGH;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end else if ((phase_reg == PH_IDLE) && led_ok) begin
                set_ok     = 1'b1;
                row_next   = '0;
                bit_next   = '0;
                tick_next  = '0;
                phase_next = PH_HIGH;
                cur_next   = (led_m1 == '0) ? new_row : ram_rdata;
            end
        end
    end

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (clearing_reg && (clr_cnt_reg != CLR_END)) begin
            clr_cnt_next = clr_cnt_reg + CW'(1);
        end
    end

    assign ram_we    = clearing_reg ? (clr_cnt_reg < CLR_END) : set_ok;
    assign ram_waddr = clearing_reg ? clr_cnt_reg[AW-1:0] : led_m1[AW-1:0];
    assign ram_wdata = clearing_reg ? '0 : new_row;
    assign ram_raddr = ((phase_reg == PH_IDLE) || (phase_reg == PH_LATCH) ||
                        (row_reg == LAST_ROW)) ? '0 : row_reg + AW'(1);

    rgbled_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_LEDS),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            row_reg      <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            if (clr_cnt_reg == CLR_END) begin
                clearing_reg <= 1'b0;
            end
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    assign clear_busy     = clearing_reg;
    assign res.line_level = (phase_next == PH_HIGH);
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.accepted   = set_ok;

    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !item_fire)
        else $error("transfer taken during clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        set_ok |=> (phase_reg == PH_HIGH) && (tick_reg == '0) && (bit_reg == '0))
        else $error("accepted set did not start frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (tick_reg == '0))
        else $error("tick count running while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg <= LAST_BIT)
        else $error("bit counter past end of row");

endmodule

### hdl/rgbled_skid.sv
// ----------------------------------------------------------------------------
// rgbled_skid
// Two-entry result buffer between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module rgbled_skid
    import rgbled_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_res,
    output logic    space,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign pop     = out_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= push_res;
            end else begin
                out_reg <= push_res;
            end
        end
    end

endmodule

### hdl/rgb_led_one_wire_serializer_unit.sv
// A transfer's result is registered in the result buffer before it appears on m_*.
// Throughput: one item per cycle while the result buffer has space; the two-entry
// result buffer keeps s_ready high while one result waits on m_ready.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the colour
// store, one LED a cycle, with s_ready low.
// Configuration writes are taken at any time, including during the clearing pass.
// ----------------------------------------------------------------------------
// rgb_led_one_wire_serializer_unit
// Addressable RGB LED one-wire serializer: APB registers, sequencer, result buffer.
// ----------------------------------------------------------------------------
module rgb_led_one_wire_serializer_unit
    import rgbled_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [LED_NUM_W-1:0]  s_led_number,
    input  logic [COLOUR_W-1:0]   s_red,
    input  logic [COLOUR_W-1:0]   s_green,
    input  logic [COLOUR_W-1:0]   s_blue,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_line_level,
    output logic                  m_busy_res,
    output logic                  m_accepted
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic       clear_busy;
    logic       space;
    logic       item_fire;
    result_t    seq_res;
    result_t    out_res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_ticks   <= SHORT_RST;
            cfg_reg.long_ticks    <= LONG_RST;
            cfg_reg.latch_ticks   <= LATCH_RST;
            cfg_reg.channel_order <= ORDER_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SHORT: cfg_reg.short_ticks   <= pwdata[SHORT_W-1:0];
                REG_LONG:  cfg_reg.long_ticks    <= pwdata[LONG_W-1:0];
                REG_LATCH: cfg_reg.latch_ticks   <= pwdata[LATCH_W-1:0];
                REG_ORDER: cfg_reg.channel_order <= pwdata[ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SHORT: prdata = APB_DATA_W'(cfg_reg.short_ticks);
            REG_LONG:  prdata = APB_DATA_W'(cfg_reg.long_ticks);
            REG_LATCH: prdata = APB_DATA_W'(cfg_reg.latch_ticks);
            REG_ORDER: prdata = APB_DATA_W'(cfg_reg.channel_order);
            default:   prdata = '0;
        endcase
    end

    assign s_ready   = space && !clear_busy;
    assign item_fire = s_valid && s_ready;

    rgbled_seq #(
        .NUM_LEDS (NUM_LEDS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_fire  (item_fire),
        .action     (s_action),
        .led_number (s_led_number),
        .red        (s_red),
        .green      (s_green),
        .blue       (s_blue),
        .res        (seq_res),
        .clear_busy (clear_busy)
    );

    rgbled_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (item_fire),
        .push_res (seq_res),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (out_res)
    );

    assign m_line_level = out_res.line_level;
    assign m_busy_res   = out_res.busy_res;
    assign m_accepted   = out_res.accepted;

endmodule
